FILE: src/bsde_pkg.sv
// Package for the BLE service-data identifier extractor.
// Holds the transaction structs, the parse phase type and the header constants.
// No dependencies; every other file refers to it by scoped names.
package bsde_pkg;

  // Default identifier length in bytes
  localparam int EID_BYTES_DEF = 20;

  // Bytes ahead of the identifier: type, two UUID bytes, frame type
  localparam int HDR_BYTES = 4;

  // Structure header values
  localparam logic [7:0] SD_TYPE    = 8'h16;
  localparam logic [7:0] UUID_FIRST = 8'hAA;
  localparam logic [7:0] UUID_SECOND = 8'hFE;
  localparam logic [7:0] FRAME_EID  = 8'h40;
  localparam logic [7:0] FRAME_EID_ALT = 8'h41;

  // Parse phase
  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_ELEMENT = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  // One input transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic       found;
    logic [7:0] frame_kind;
    logic [7:0] eid_byte;
    logic [4:0] byte_index;
    logic       last_result;
  } out_item_t;

  // Parser to emitter hand-over at the end of a payload
  typedef struct packed {
    logic       fire;
    logic       found;
    logic [7:0] frame_kind;
  } load_t;

endpackage

FILE: src/ble_service_data_eid_extractor.sv
// Top level of the BLE service-data identifier extractor.
// Joins the structure parser and the result emitter; depends on bsde_pkg.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_stall    bsde_pkg::in_item_t
//   result   out        result_valid / result_stall bsde_pkg::out_item_t
//
// A byte is taken each cycle unless stalled; the parser updates in that cycle.
// The final byte of a payload loads the emitter, which gives one not-found result
// or EID_BYTES identifier results, one per cycle while result_stall is low.
// Non-final bytes of the next payload are taken while a run is still going out;
// a final byte is stalled until the emitter releases its last result.
// rst is synchronous and clears the parse and any pending run.
module ble_service_data_eid_extractor #(
  parameter int EID_BYTES = bsde_pkg::EID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bsde_pkg::in_item_t  item,
  input  logic                item_valid,
  output logic                item_stall,
  output bsde_pkg::out_item_t result,
  output logic                result_valid,
  input  logic                result_stall
);

  bsde_pkg::load_t           load;
  logic [EID_BYTES-1:0][7:0] eid_next;
  logic                      load_ready;
  logic                      take;

  // Stall only a final byte that finds the emitter still occupied
  assign item_stall = item.last_byte && !load_ready;
  assign take       = item_valid && !item_stall;

  bsde_parser #(
    .EID_BYTES (EID_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .load     (load),
    .eid_next (eid_next)
  );

  bsde_emitter #(
    .EID_BYTES (EID_BYTES)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .eid_in       (eid_next),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .load_ready   (load_ready)
  );

endmodule

FILE: src/bsde_parser.sv
// Length-type-data walker for the identifier extractor.
// Tracks the current structure, checks its header and captures identifier bytes.
// Depends on bsde_pkg.
module bsde_parser #(
  parameter int EID_BYTES = bsde_pkg::EID_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  bsde_pkg::in_item_t            item,
  output bsde_pkg::load_t               load,
  output logic [EID_BYTES-1:0][7:0]     eid_next
);

  localparam logic [7:0] POS_TYPE   = 8'd1;
  localparam logic [7:0] POS_UUID0  = 8'd2;
  localparam logic [7:0] POS_UUID1  = 8'd3;
  localparam logic [7:0] POS_FRAME  = 8'd4;
  localparam logic [8:0] MIN_LENGTH = 9'(bsde_pkg::HDR_BYTES + EID_BYTES);

  bsde_pkg::phase_t phase, phase_next;
  logic [7:0] elem_len, elem_len_next;
  logic [7:0] elem_off, elem_off_next;
  logic       hdr_ok, hdr_ok_next;
  logic [7:0] cand_frame, cand_frame_next;
  logic       confirmed, confirmed_next;
  logic [EID_BYTES-1:0][7:0] store;

  logic [7:0] off_inc;
  logic       hdr_step;
  logic [7:0] frame_step;
  logic       complete;
  logic       confirmed_step;
  logic       end_of_payload;

  assign end_of_payload = take && item.last_byte;

  // Header check for the byte about to land in the current structure
  always_comb begin
    off_inc    = elem_off + 8'd1;
    hdr_step   = hdr_ok;
    frame_step = cand_frame;
    case (off_inc)
      POS_TYPE:  hdr_step = (item.payload_byte == bsde_pkg::SD_TYPE) &&
                            ({1'b0, elem_len} >= MIN_LENGTH);
      POS_UUID0: hdr_step = hdr_ok && (item.payload_byte == bsde_pkg::UUID_FIRST);
      POS_UUID1: hdr_step = hdr_ok && (item.payload_byte == bsde_pkg::UUID_SECOND);
      POS_FRAME: begin
        frame_step = item.payload_byte;
        hdr_step   = hdr_ok && ((item.payload_byte == bsde_pkg::FRAME_EID) ||
                                (item.payload_byte == bsde_pkg::FRAME_EID_ALT));
      end
      default: ;
    endcase
    complete       = (off_inc == elem_len);
    confirmed_step = confirmed ||
                     (take && (phase == bsde_pkg::PH_ELEMENT) && complete && hdr_step);
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        bsde_pkg::PH_LENGTH: begin
          phase_next = (item.payload_byte == 8'd0) ? bsde_pkg::PH_STOPPED
                                                   : bsde_pkg::PH_ELEMENT;
        end
        bsde_pkg::PH_ELEMENT: begin
          if (complete) begin
            phase_next = hdr_step ? bsde_pkg::PH_STOPPED : bsde_pkg::PH_LENGTH;
          end
        end
        bsde_pkg::PH_STOPPED: ;
        default: phase_next = bsde_pkg::PH_LENGTH;
      endcase
      if (item.last_byte) begin
        phase_next = bsde_pkg::PH_LENGTH;
      end
    end
  end

  // Structure registers; clear them at the end of every payload
  always_comb begin
    elem_len_next   = elem_len;
    elem_off_next   = elem_off;
    hdr_ok_next     = hdr_ok;
    cand_frame_next = cand_frame;
    confirmed_next  = confirmed_step;
    if (take && (phase == bsde_pkg::PH_LENGTH) && (item.payload_byte != 8'd0)) begin
      elem_len_next = item.payload_byte;
      elem_off_next = 8'd0;
      hdr_ok_next   = 1'b0;
    end
    if (take && (phase == bsde_pkg::PH_ELEMENT)) begin
      elem_off_next   = off_inc;
      hdr_ok_next     = hdr_step;
      cand_frame_next = frame_step;
    end
    if (end_of_payload) begin
      elem_len_next   = 8'd0;
      elem_off_next   = 8'd0;
      hdr_ok_next     = 1'b0;
      cand_frame_next = 8'd0;
      confirmed_next  = 1'b0;
    end
  end

  // Capture identifier bytes by their position in the structure
  always_comb begin
    eid_next = store;
    for (int k = 0; k < EID_BYTES; k++) begin
      if (take && (phase == bsde_pkg::PH_ELEMENT) && (off_inc == 8'(k + 5))) begin
        eid_next[k] = item.payload_byte;
      end
    end
  end

  // Hand the outcome to the emitter on the final byte
  always_comb begin
    load.fire       = end_of_payload;
    load.found      = confirmed_step;
    load.frame_kind = confirmed_step ? frame_step : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= bsde_pkg::PH_LENGTH;
      elem_len   <= 8'd0;
      elem_off   <= 8'd0;
      hdr_ok     <= 1'b0;
      cand_frame <= 8'd0;
      confirmed  <= 1'b0;
    end else begin
      phase      <= phase_next;
      elem_len   <= elem_len_next;
      elem_off   <= elem_off_next;
      hdr_ok     <= hdr_ok_next;
      cand_frame <= cand_frame_next;
      confirmed  <= confirmed_next;
    end
  end

  // Identifier store; contents only matter after a confirmed match
  always_ff @(posedge clk) begin
    store <= eid_next;
  end

endmodule

FILE: src/bsde_emitter.sv
// Result emitter for the identifier extractor.
// Holds a snapshot of one payload outcome and shifts it out one result at a time.
// Depends on bsde_pkg.
module bsde_emitter #(
  parameter int EID_BYTES = bsde_pkg::EID_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bsde_pkg::load_t           load,
  input  logic [EID_BYTES-1:0][7:0] eid_in,
  output bsde_pkg::out_item_t       result,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      load_ready
);

  localparam logic [4:0] LAST_INDEX = 5'(EID_BYTES - 1);

  logic                      busy;
  logic                      found;
  logic [7:0]                frame;
  logic [4:0]                idx;
  logic [EID_BYTES-1:0][7:0] eid_buf;
  logic                      out_fire;
  logic                      out_last;

  // Present the head of the snapshot
  always_comb begin
    out_last           = !found || (idx == LAST_INDEX);
    result.found       = found;
    result.frame_kind  = frame;
    result.eid_byte    = found ? eid_buf[0] : 8'd0;
    result.byte_index  = idx;
    result.last_result = out_last;
  end

  assign result_valid = busy;
  assign out_fire     = busy && !result_stall;
  assign load_ready   = !busy || (out_fire && out_last);

  // Hold, advance or release the run
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 5'd0;
    end else if (load.fire) begin
      busy <= 1'b1;
      idx  <= 5'd0;
    end else if (out_fire) begin
      if (out_last) begin
        busy <= 1'b0;
      end
      idx <= idx + 5'd1;
    end
  end

  // Snapshot payload; shift one byte per delivered transaction
  always_ff @(posedge clk) begin
    if (load.fire) begin
      found   <= load.found;
      frame   <= load.frame_kind;
      eid_buf <= eid_in;
    end else if (out_fire) begin
      eid_buf <= eid_buf >> 8;
    end
  end

endmodule

FILE: src/bsde_checker.sv
// Port-level checks for the identifier extractor, bound to its top level.
// Watches only the top-level ports; depends on bsde_pkg.
module bsde_checker (
  input logic                clk,
  input logic                rst,
  input bsde_pkg::in_item_t  item,
  input logic                item_valid,
  input logic                item_stall,
  input bsde_pkg::out_item_t result,
  input logic                result_valid,
  input logic                result_stall
);

  // Hold a stalled result transaction
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Advance the identifier index by one within a run
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last_result |=>
      result_valid && (result.byte_index == $past(result.byte_index) + 5'd1))
    else $error("identifier run broken");

  // A not-found result stands alone and carries zeros
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.last_result && (result.eid_byte == 8'd0) &&
      (result.frame_kind == 8'd0) && (result.byte_index == 5'd0))
    else $error("malformed not-found result");

  // A found result names a valid frame type
  a_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |->
      (result.frame_kind == bsde_pkg::FRAME_EID) ||
      (result.frame_kind == bsde_pkg::FRAME_EID_ALT))
    else $error("bad frame type");

  // Stall only final bytes
  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |-> item.last_byte)
    else $error("non-final byte stalled");

endmodule

bind ble_service_data_eid_extractor bsde_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item         (item),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);
